// ===== hw/rtl/isfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isfd_pkg: shared types and constants
// Sample, folded pair-sum and queue word types for the I/Q FIR decimator.
// ----------------------------------------------------------------------------
package isfd_pkg;

  localparam int TAP_COUNT  = 16;
  localparam int PAIR_COUNT = TAP_COUNT / 2;
  localparam int PAIR_W     = $clog2(PAIR_COUNT);
  localparam int BYTE_W     = 8;
  localparam int SAMPLE_W   = 9;   // 2*b-255 in -255..255
  localparam int SUM_W      = 10;  // sum of two samples
  localparam int OUT_W      = 28;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = PAIR_W + 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    pair_t;

  // one queue word: folded tap pairs of both channels at a decimation point
  typedef struct packed {
    pair_t [PAIR_COUNT-1:0] i_pair;
    pair_t [PAIR_COUNT-1:0] q_pair;
  } entry_t;

  typedef struct packed {
    logic full;
    logic nempty;
  } q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/isfd_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isfd_cfg: coefficient register file
// APB-style slave holding the eight folded-pair coefficients.
// ----------------------------------------------------------------------------
module isfd_cfg #(
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     psel,
  input  wire logic                                     penable,
  input  wire logic                                     pwrite,
  input  wire logic [isfd_pkg::APB_ADDR_W-1:0]          paddr,
  input  wire logic [isfd_pkg::APB_DATA_W-1:0]          pwdata,
  output logic      [isfd_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                          pready,
  output logic [isfd_pkg::PAIR_COUNT-1:0][COEF_WIDTH-1:0] coef
);

  logic [isfd_pkg::PAIR_W-1:0] reg_idx;
  logic                        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[isfd_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr_en) begin
      coef[reg_idx] <= pwdata[COEF_WIDTH-1:0];
    end
  end

  // reads return the coefficient sign-extended to the bus width
  assign prdata = isfd_pkg::APB_DATA_W'($signed(coef[reg_idx]));

endmodule

`default_nettype wire

// ===== hw/rtl/isfd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isfd_front: input stage
// Converts byte pairs to samples, runs the delay lines and the phase count,
// and pushes folded pair sums into the queue at each decimation point.
// ----------------------------------------------------------------------------
module isfd_front #(
  parameter int DECIMATION = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [isfd_pkg::BYTE_W-1:0]   i_byte,
  input  wire logic [isfd_pkg::BYTE_W-1:0]   q_byte,
  input  wire isfd_pkg::q_status_t           q_stat,
  output logic                               push,
  output isfd_pkg::entry_t                   push_entry
);

  localparam int PH_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(DECIMATION - 1);

  isfd_pkg::sample_t i_line      [isfd_pkg::TAP_COUNT];
  isfd_pkg::sample_t q_line      [isfd_pkg::TAP_COUNT];
  isfd_pkg::sample_t i_line_next [isfd_pkg::TAP_COUNT];
  isfd_pkg::sample_t q_line_next [isfd_pkg::TAP_COUNT];
  isfd_pkg::sample_t i_sample;
  isfd_pkg::sample_t q_sample;
  logic [PH_W-1:0]   phase;
  logic              accept;
  logic [isfd_pkg::SUM_W-1:0] i_twice;
  logic [isfd_pkg::SUM_W-1:0] q_twice;

  // conservative: hold off whenever the queue is full
  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~q_stat.full;

  // 2*b - 255 fits in 9 bits, so the low bits of the 10-bit difference are exact
  assign i_twice  = {1'b0, i_byte, 1'b0} - isfd_pkg::SUM_W'(255);
  assign q_twice  = {1'b0, q_byte, 1'b0} - isfd_pkg::SUM_W'(255);
  assign i_sample = $signed(i_twice[isfd_pkg::SAMPLE_W-1:0]);
  assign q_sample = $signed(q_twice[isfd_pkg::SAMPLE_W-1:0]);

  always_comb begin
    for (int k = 0; k < isfd_pkg::TAP_COUNT - 1; k++) begin
      i_line_next[k] = i_line[k+1];
      q_line_next[k] = q_line[k+1];
    end
    i_line_next[isfd_pkg::TAP_COUNT-1] = i_sample;
    q_line_next[isfd_pkg::TAP_COUNT-1] = q_sample;
  end

  // fold tap k with tap 15-k on the line as it stands after this word
  always_comb begin
    for (int k = 0; k < isfd_pkg::PAIR_COUNT; k++) begin
      push_entry.i_pair[k] = isfd_pkg::SUM_W'(i_line_next[k])
                           + isfd_pkg::SUM_W'(i_line_next[isfd_pkg::TAP_COUNT-1-k]);
      push_entry.q_pair[k] = isfd_pkg::SUM_W'(q_line_next[k])
                           + isfd_pkg::SUM_W'(q_line_next[isfd_pkg::TAP_COUNT-1-k]);
    end
  end

  assign push = accept && (phase == PH_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      for (int k = 0; k < isfd_pkg::TAP_COUNT; k++) begin
        i_line[k] <= '0;
        q_line[k] <= '0;
      end
    end else if (accept) begin
      phase  <= (phase == PH_LAST) ? '0 : phase + 1'b1;
      i_line <= i_line_next;
      q_line <= q_line_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/isfd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isfd_queue: pair-sum queue
// Two-entry FIFO between the input stage and the MAC sequencer.
// ----------------------------------------------------------------------------
module isfd_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire isfd_pkg::entry_t      push_entry,
  input  wire logic                  pop,
  output isfd_pkg::entry_t           head,
  output isfd_pkg::q_status_t        q_stat
);

  isfd_pkg::entry_t              mem [isfd_pkg::Q_DEPTH];
  logic [isfd_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [isfd_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic [isfd_pkg::Q_CNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head          = mem[rd_ptr];
  assign q_stat.full   = (count == isfd_pkg::Q_CNT_W'(isfd_pkg::Q_DEPTH));
  assign q_stat.nempty = (count != '0);

endmodule

`default_nettype wire

// ===== hw/rtl/isfd_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// isfd_back: MAC sequencer
// Walks the eight tap pairs of the head queue word, one multiply per channel
// per cycle unless a held output freezes it, accumulates and loads the output register.
// ----------------------------------------------------------------------------
module isfd_back #(
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst,
  input  wire isfd_pkg::entry_t                             head,
  input  wire isfd_pkg::q_status_t                          q_stat,
  input  wire logic [isfd_pkg::PAIR_COUNT-1:0][COEF_WIDTH-1:0] coef,
  output logic                                              pop,
  output logic                                              out_valid,
  input  wire logic                                         out_stall,
  output logic signed [isfd_pkg::OUT_W-1:0]                 i_out,
  output logic signed [isfd_pkg::OUT_W-1:0]                 q_out
);

  localparam int PROD_W = COEF_WIDTH + isfd_pkg::SUM_W;
  localparam int MUL_W  = (PROD_W > isfd_pkg::OUT_W) ? PROD_W : isfd_pkg::OUT_W;
  localparam logic [isfd_pkg::PAIR_W-1:0] IDX_LAST = isfd_pkg::PAIR_W'(isfd_pkg::PAIR_COUNT - 1);

  logic [isfd_pkg::PAIR_W-1:0]       idx;
  logic                              issue;
  logic                              advance;
  logic signed [COEF_WIDTH-1:0]      coef_sel;
  logic signed [MUL_W-1:0]           mul_i;
  logic signed [MUL_W-1:0]           mul_q;
  logic signed [isfd_pkg::OUT_W-1:0] prod_i;
  logic signed [isfd_pkg::OUT_W-1:0] prod_q;
  logic                              prod_v;
  logic                              prod_first;
  logic                              prod_last;
  logic signed [isfd_pkg::OUT_W-1:0] acc_i;
  logic signed [isfd_pkg::OUT_W-1:0] acc_q;
  logic signed [isfd_pkg::OUT_W-1:0] sum_i;
  logic signed [isfd_pkg::OUT_W-1:0] sum_q;

  // whole pipe freezes only when a finished sum has nowhere to go
  assign advance = ~(prod_v & prod_last & out_valid & out_stall);
  assign issue   = q_stat.nempty & advance;
  assign pop     = issue & (idx == IDX_LAST);

  assign coef_sel = $signed(coef[idx]);
  assign mul_i    = MUL_W'(coef_sel) * MUL_W'($signed(head.i_pair[idx]));
  assign mul_q    = MUL_W'(coef_sel) * MUL_W'($signed(head.q_pair[idx]));

  assign sum_i = (prod_first ? '0 : acc_i) + prod_i;
  assign sum_q = (prod_first ? '0 : acc_q) + prod_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      prod_v     <= 1'b0;
      prod_first <= 1'b0;
      prod_last  <= 1'b0;
    end else if (advance) begin
      prod_v <= issue;
      if (issue) begin
        idx        <= idx + 1'b1;
        prod_first <= (idx == '0);
        prod_last  <= (idx == IDX_LAST);
      end
    end
  end

  // products wrap to the output width, same as the final sum
  always_ff @(posedge clk) begin
    if (advance && issue) begin
      prod_i <= mul_i[isfd_pkg::OUT_W-1:0];
      prod_q <= mul_q[isfd_pkg::OUT_W-1:0];
    end
    if (advance && prod_v) begin
      acc_i <= sum_i;
      acc_q <= sum_q;
    end
    if (advance && prod_v && prod_last) begin
      i_out <= sum_i;
      q_out <= sum_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && prod_v && prod_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iq_symmetric_fir_decimator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// iq_symmetric_fir_decimator: 16-tap symmetric I/Q FIR, decimate by DECIMATION
// Offset-binary byte pairs in, one full-precision filtered pair out per
// DECIMATION input words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall, i_byte/q_byte): one word per cycle is
// taken as long as the two-entry pair-sum queue has room. The input stage
// updates the delay lines on every word and, on each DECIMATION-th word,
// queues the eight folded tap-pair sums of both channels.
// MAC sequencer: one coefficient multiply per channel per cycle unless a held
// output freezes it; results are back to back while the queue holds words.
// The deciding word's pair sums pass the queue and the product registers into
// the output register. With DECIMATION >= 8 the input is never stalled unless
// the output is; with smaller DECIMATION the sequencer sets the input rate.
// Output channel (out_valid/out_stall, i_out/q_out): a registered result is
// held while out_stall is high; the sequencer freezes on its next finished
// sum, then the queue fills and in_stall rises.
// Reset clears delay lines, phase count, queue, coefficients and out_valid.
// Coefficients are written over APB at byte address 4*k; reads return them
// sign-extended.
// ----------------------------------------------------------------------------
module iq_symmetric_fir_decimator #(
  parameter int DECIMATION = 8,
  parameter int COEF_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [isfd_pkg::BYTE_W-1:0]          i_byte,
  input  wire logic [isfd_pkg::BYTE_W-1:0]          q_byte,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [isfd_pkg::OUT_W-1:0]         i_out,
  output logic signed [isfd_pkg::OUT_W-1:0]         q_out,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [isfd_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [isfd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [isfd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready
);

  logic [isfd_pkg::PAIR_COUNT-1:0][COEF_WIDTH-1:0] coef;
  isfd_pkg::entry_t    push_entry;
  isfd_pkg::entry_t    head;
  isfd_pkg::q_status_t q_stat;
  logic                push;
  logic                pop;

  isfd_cfg #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  isfd_front #(
    .DECIMATION (DECIMATION)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .i_byte     (i_byte),
    .q_byte     (q_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  isfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  isfd_back #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .coef      (coef),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .i_out     (i_out),
    .q_out     (q_out)
  );

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.nempty)
    else $error("pair-sum queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("pair-sum queue pushed while full");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !q_stat.nempty)
    else $error("output or queue not idle after reset");
`endif

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for iq_symmetric_fir_decimator
// Loads coefficient sets over APB while the block is idle. Feeds directed
// and random I/Q byte words with random gaps and output stalls. Checks each
// decimated output word against a folded-FIR predictor kept in a small
// scoreboard class.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [isfd_pkg::OUT_W-1:0] i_val;
  logic signed [isfd_pkg::OUT_W-1:0] q_val;
} fir_sum_t;

class decim_scoreboard;
  localparam int TAPS  = isfd_pkg::TAP_COUNT;
  localparam int PAIRS = isfd_pkg::PAIR_COUNT;
  localparam int MAX_REPORTS = 10;

  int decim;
  logic signed [15:0] coef [PAIRS];
  isfd_pkg::sample_t i_line [TAPS];
  isfd_pkg::sample_t q_line [TAPS];
  int phase_cnt;
  fir_sum_t pending_sums [$];
  int errors;

  function new(int decimation);
    decim = decimation;
    foreach (coef[k]) coef[k] = '0;
    foreach (i_line[k]) begin
      i_line[k] = '0;
      q_line[k] = '0;
    end
    phase_cnt = 0;
    errors = 0;
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function int pending();
    return pending_sums.size();
  endfunction

  // only the low 16 bits are kept, sign taken from bit 15
  function void set_coef(int k, logic [31:0] w);
    coef[k] = w[15:0];
  endfunction

  function isfd_pkg::sample_t to_sample(logic [7:0] b);
    int v;
    v = 2 * int'(b) - 255;
    return v[isfd_pkg::SAMPLE_W-1:0];
  endfunction

  function logic signed [isfd_pkg::OUT_W-1:0] fold(isfd_pkg::sample_t line [TAPS]);
    longint acc;
    acc = 0;
    for (int k = 0; k < PAIRS; k++)
      acc += longint'(coef[k]) * (longint'(line[k]) + longint'(line[TAPS-1-k]));
    return acc[isfd_pkg::OUT_W-1:0];
  endfunction

  function void note_word(logic [7:0] ib, logic [7:0] qb);
    fir_sum_t r;
    for (int k = 0; k < TAPS - 1; k++) begin
      i_line[k] = i_line[k+1];
      q_line[k] = q_line[k+1];
    end
    i_line[TAPS-1] = to_sample(ib);
    q_line[TAPS-1] = to_sample(qb);
    phase_cnt++;
    if (phase_cnt >= decim) begin
      phase_cnt = 0;
      r.i_val = fold(i_line);
      r.q_val = fold(q_line);
      pending_sums.push_back(r);
    end
  endfunction

  function void check_word(logic signed [isfd_pkg::OUT_W-1:0] iv,
                           logic signed [isfd_pkg::OUT_W-1:0] qv);
    fir_sum_t r;
    if (pending_sums.size() == 0) begin
      flag($sformatf("output word with none expected: i=%0d q=%0d", iv, qv));
      return;
    end
    r = pending_sums.pop_front();
    if (iv !== r.i_val)
      flag($sformatf("i_out mismatch: expected %0d, got %0d", r.i_val, iv));
    if (qv !== r.q_val)
      flag($sformatf("q_out mismatch: expected %0d, got %0d", r.q_val, qv));
  endfunction
endclass

module tb_top;
  localparam int DECIM       = 8;
  localparam int ADDR_W      = isfd_pkg::APB_ADDR_W;
  localparam int PAIRS       = isfd_pkg::PAIR_COUNT;
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_WORDS = 160;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {SET_MIN, SET_MAX, SET_ALT, SET_SMALL, SET_RANDOM} coef_set_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [isfd_pkg::BYTE_W-1:0] i_byte;
  logic [isfd_pkg::BYTE_W-1:0] q_byte;
  logic out_valid;
  logic out_stall;
  logic signed [isfd_pkg::OUT_W-1:0] i_out;
  logic signed [isfd_pkg::OUT_W-1:0] q_out;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [isfd_pkg::APB_DATA_W-1:0] pwdata;
  logic [isfd_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  decim_scoreboard sb;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit long_hold_req = 1'b0;
  int cycle_cnt = 0;

  iq_symmetric_fir_decimator #(
    .DECIMATION(DECIM),
    .COEF_WIDTH(16)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .i_byte(i_byte),
    .q_byte(q_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .i_out(i_out),
    .q_out(q_out),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // both handshakes seen with pre-edge values
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (out_valid && !out_stall) sb.check_word(i_out, q_out);
      if (in_valid && !in_stall) sb.note_word(i_byte, q_byte);
    end
  end

  // receiver: short random stall bursts, or one long hold on request
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0: b = 8'h00;
      1: b = 8'hff;
      2: b = ($urandom_range(0, 1) != 0) ? 8'h7f : 8'h80;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic logic [31:0] pick_coef(coef_set_t s, int k);
    logic signed [15:0] c;
    logic [31:0] w;
    case (s)
      SET_MIN:   c = 16'sh8000;
      SET_MAX:   c = 16'sh7fff;
      SET_ALT:   c = k[0] ? 16'sh8000 : 16'sh7fff;
      SET_SMALL: c = 16'($urandom_range(0, 511)) - 16'sd256;
      default:   c = 16'($urandom);
    endcase
    // upper bits are junk on even taps, proper sign extension on odd ones
    w = $urandom;
    if (k[0]) w[31:16] = {16{c[15]}};
    w[15:0] = c;
    return w;
  endfunction

  task automatic load_coefs(input coef_set_t s);
    logic [31:0] w;
    for (int k = 0; k < PAIRS; k++) begin
      w = pick_coef(s, k);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(k * 4);
      pwdata  <= w;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      sb.set_coef(k, w);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_word(input logic [7:0] ib, input logic [7:0] qb);
    in_valid <= 1'b1;
    i_byte   <= ib;
    q_byte   <= qb;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_words(input int count, input bit with_hold);
    for (int n = 0; n < count; n++) begin
      if (with_hold && n == 20) long_hold_req = 1'b1;
      // no gaps during the long hold so the block backs up
      if (tx_idle_en && !long_hold_req && $urandom_range(0, 4) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      send_word(pick_byte(), pick_byte());
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [7:0] dir_i [8];
    logic [7:0] dir_q [8];
    coef_set_t phase_set [6];
    dir_i = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h00, 8'hff, 8'h01, 8'hfe};
    dir_q = '{8'hff, 8'h00, 8'h7f, 8'h80, 8'h00, 8'hff, 8'hfe, 8'h01};
    phase_set = '{SET_MAX, SET_RANDOM, SET_ALT, SET_SMALL, SET_RANDOM, SET_RANDOM};
    sb = new(DECIM);
    rst = 1'b1;
    in_valid = 1'b0;
    i_byte = '0;
    q_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficients are zero: first word must be all zero
    for (int n = 0; n < DECIM; n++) send_word(dir_i[n], dir_q[n]);
    in_valid <= 1'b0;
    wait_drain();

    // full-scale corner: all taps at -1.0, I pinned high, Q pinned low
    load_coefs(SET_MIN);
    for (int n = 0; n < 2 * DECIM; n++) send_word(8'hff, 8'h00);
    in_valid <= 1'b0;
    wait_drain();

    for (int p = 0; p < 6; p++) begin
      tx_idle_en = (p != 5);
      rx_idle_en = (p != 5);
      load_coefs(phase_set[p]);
      if (p == 2) begin
        run_words(PHASE_WORDS, 1'b1);
      end else if (p == 3) begin
        run_words(PHASE_WORDS / 2, 1'b0);
        wait_drain();
        run_words(PHASE_WORDS / 2, 1'b0);
      end else begin
        run_words(PHASE_WORDS, 1'b0);
      end
      wait_drain();
    end

    if (sb.pending() != 0) sb.flag("output words still expected at end of run");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/isfd_pkg.sv
hw/rtl/isfd_cfg.sv
hw/rtl/isfd_front.sv
hw/rtl/isfd_queue.sv
hw/rtl/isfd_back.sv
hw/rtl/iq_symmetric_fir_decimator.sv
test/tb_top.sv
